// ===== design/ims_pkg.sv =====
// ----------------------------------------------------------------------------
// ims_pkg
// Shared types and constants for the Ising Metropolis spin update block.
// ----------------------------------------------------------------------------
package ims_pkg;

	localparam int COORD_W      = 6;
	localparam int LATTICE_SIDE = 1 << COORD_W;
	localparam int ADDR_W       = 2 * COORD_W;
	localparam int SITE_COUNT   = LATTICE_SIDE * LATTICE_SIDE;
	localparam int SPIN_W       = 2;
	localparam int NSUM_W       = 4;
	localparam int FRAC_W       = 32;
	localparam int MAG_W        = 14;
	localparam int ENERGY_W     = 15;
	localparam int CFG_IDX_W    = 1;
	localparam int ROOT_W       = 32;
	localparam int RAD_W        = 2 * ROOT_W;
	localparam int SQ_ITER      = ROOT_W;
	localparam int SQ_CNT_W     = $clog2(SQ_ITER);

	localparam logic [CFG_IDX_W-1:0] REG_THR_TWO  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_THR_FOUR = 1'b1;

	localparam logic OP_WRITE   = 1'b0;
	localparam logic OP_ATTEMPT = 1'b1;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_SQ1,
		S_SQ3,
		S_RC,
		S_RU,
		S_RD,
		S_RL,
		S_RR,
		S_SUM,
		S_EVAL
	} ctrl_state_t;

	typedef enum logic [2:0] {
		SITE_C,
		SITE_U,
		SITE_D,
		SITE_L,
		SITE_R
	} site_sel_t;

	typedef enum logic {
		SQ_ONE,
		SQ_THREE
	} sq_sel_t;

	typedef struct packed {
		logic      item_load;
		logic      rd_en;
		site_sel_t rd_sel;
		logic      cap_center;
		logic      acc_add;
		logic      eval;
		logic      clr_step;
		logic      sq_start;
		sq_sel_t   sq_sel;
		logic      sq_store1;
		logic      sq_store3;
	} ims_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic sq_done;
		logic cfg_wr;
	} ims_stat_t;

endpackage

// ===== design/ims_ram.sv =====
// ----------------------------------------------------------------------------
// ims_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module ims_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 4096,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== design/ims_sqrt.sv =====
// ----------------------------------------------------------------------------
// ims_sqrt
// Iterative integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module ims_sqrt import ims_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [RAD_W-1:0]  radicand,
	output logic              done,
	output logic [ROOT_W-1:0] root
);

	logic [RAD_W-1:0]    rem_q;
	logic [RAD_W-1:0]    res_q;
	logic [RAD_W-1:0]    bit_q;
	logic [SQ_CNT_W-1:0] cnt_q;
	logic                run_q;
	logic                done_q;
	logic [RAD_W-1:0]    trial;
	logic                ge;

	assign trial = res_q + bit_q;
	assign ge    = (rem_q >= trial);
	assign done  = done_q;
	assign root  = res_q[ROOT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			run_q  <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (run_q) begin
			cnt_q  <= cnt_q + 1'b1;
			run_q  <= (cnt_q != SQ_CNT_W'(SQ_ITER - 1));
			done_q <= (cnt_q == SQ_CNT_W'(SQ_ITER - 1));
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= radicand;
			res_q <= '0;
			bit_q <= RAD_W'(1) << (RAD_W - 2);
		end else if (run_q) begin
			if (ge) begin
				rem_q <= rem_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

endmodule

// ===== design/ims_datapath.sv =====
// ----------------------------------------------------------------------------
// ims_datapath
// Spin store, neighbour sum, acceptance test, running totals and thresholds.
// ----------------------------------------------------------------------------
module ims_datapath import ims_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  ims_cmd_t                   cmd,
	output ims_stat_t                  stat,
	input  logic                       cfg_valid,
	input  logic                       cfg_ready,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [FRAC_W-1:0]          cfg_data,
	input  logic                       opcode,
	input  logic [COORD_W-1:0]         row,
	input  logic [COORD_W-1:0]         col,
	input  logic signed [SPIN_W-1:0]   spin_value,
	input  logic [FRAC_W-1:0]          random_fraction,
	output logic                       done,
	output logic signed [SPIN_W-1:0]   site_spin,
	output logic                       flipped,
	output logic signed [MAG_W-1:0]    magnetization,
	output logic signed [ENERGY_W-1:0] energy
);

	// item registers
	logic                     op_q;
	logic [COORD_W-1:0]       row_q;
	logic [COORD_W-1:0]       col_q;
	logic signed [SPIN_W-1:0] sv_q;
	logic [FRAC_W-1:0]        frac_q;

	// thresholds
	logic [FRAC_W-1:0] thr1_q;
	logic [FRAC_W-1:0] thr2_q;
	logic [FRAC_W-1:0] thr3_q;
	logic [FRAC_W-1:0] thr4_q;
	logic [RAD_W-1:0]  prod_q;

	logic [ADDR_W-1:0]        clr_q;
	logic signed [SPIN_W-1:0] center_q;
	logic signed [NSUM_W-1:0] acc_q;
	logic signed [MAG_W-1:0]    mag_q;
	logic signed [ENERGY_W-1:0] en_q;
	logic                       done_q;
	logic signed [SPIN_W-1:0]   site_spin_q;
	logic                       flipped_q;

	logic                     cfg_wr;
	logic                     ram_we;
	logic [ADDR_W-1:0]        ram_waddr;
	logic [SPIN_W-1:0]        ram_wdata;
	logic [ADDR_W-1:0]        ram_raddr;
	logic [SPIN_W-1:0]        ram_rdata;
	logic [COORD_W-1:0]       rd_row;
	logic [COORD_W-1:0]       rd_col;
	logic [RAD_W-1:0]         radicand;
	logic                     sq_done;
	logic [ROOT_W-1:0]        sq_root;

	logic signed [NSUM_W-1:0] n_sum;
	logic signed [NSUM_W-1:0] d_val;
	logic [FRAC_W-1:0]        thr_sel;
	logic                     do_flip;
	logic signed [SPIN_W-1:0] new_spin;
	logic signed [2:0]        dm;
	logic signed [6:0]        dm_x;
	logic signed [6:0]        n_x;
	logic signed [6:0]        de;

	assign cfg_wr = cfg_valid & cfg_ready;

	assign stat.clr_last = &clr_q;
	assign stat.sq_done  = sq_done;
	assign stat.cfg_wr   = cfg_wr;

	assign done          = done_q;
	assign site_spin     = site_spin_q;
	assign flipped       = flipped_q;
	assign magnetization = mag_q;
	assign energy        = en_q;

	// neighbour coordinates, periodic wrap
	always_comb begin
		rd_row = row_q;
		rd_col = col_q;
		case (cmd.rd_sel)
			SITE_C: begin
				rd_row = row_q;
			end
			SITE_U: begin
				rd_row = (row_q == '0) ? COORD_W'(LATTICE_SIDE - 1) : row_q - 1'b1;
			end
			SITE_D: begin
				rd_row = (row_q == COORD_W'(LATTICE_SIDE - 1)) ? '0 : row_q + 1'b1;
			end
			SITE_L: begin
				rd_col = (col_q == '0) ? COORD_W'(LATTICE_SIDE - 1) : col_q - 1'b1;
			end
			SITE_R: begin
				rd_col = (col_q == COORD_W'(LATTICE_SIDE - 1)) ? '0 : col_q + 1'b1;
			end
			default: begin
				rd_row = row_q;
			end
		endcase
	end

	assign ram_raddr = {rd_row, rd_col};

	// acceptance test and site update
	always_comb begin
		n_sum = acc_q;
		d_val = (center_q == SPIN_W'(1)) ? n_sum : -n_sum;
		case (d_val)
			NSUM_W'(1): thr_sel = thr1_q;
			NSUM_W'(2): thr_sel = thr2_q;
			NSUM_W'(3): thr_sel = thr3_q;
			default:    thr_sel = thr4_q;
		endcase
		do_flip = (op_q == OP_ATTEMPT) && (center_q != '0)
			&& ((d_val <= 0) || (frac_q < thr_sel));
		if (op_q == OP_WRITE) begin
			case (sv_q)
				2'sd0:   new_spin = 2'sd0;
				2'sd1:   new_spin = 2'sd1;
				default: new_spin = -2'sd1;
			endcase
		end else begin
			new_spin = do_flip ? -center_q : center_q;
		end
		dm   = 3'(new_spin) - 3'(center_q);
		dm_x = 7'(dm);
		n_x  = 7'(n_sum);
		de   = -(dm_x * n_x);
	end

	always_comb begin
		if (cmd.clr_step) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = '0;
		end else begin
			ram_we    = cmd.eval;
			ram_waddr = {row_q, col_q};
			ram_wdata = new_spin;
		end
	end

	assign radicand = (cmd.sq_sel == SQ_ONE) ? {thr2_q, {FRAC_W{1'b0}}} : prod_q;

	ims_ram #(
		.WIDTH(SPIN_W),
		.DEPTH(SITE_COUNT)
	) u_spin_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd.rd_en),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	ims_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.sq_start),
		.radicand (radicand),
		.done     (sq_done),
		.root     (sq_root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr1_q <= '0;
			thr2_q <= '0;
			thr3_q <= '0;
			thr4_q <= '0;
			clr_q  <= '0;
			mag_q  <= '0;
			en_q   <= '0;
			done_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				case (cfg_index)
					REG_THR_TWO:  thr2_q <= cfg_data;
					REG_THR_FOUR: thr4_q <= cfg_data;
					default:      thr2_q <= thr2_q;
				endcase
			end
			if (cmd.sq_store1) begin
				thr1_q <= sq_root;
			end
			if (cmd.sq_store3) begin
				thr3_q <= sq_root;
			end
			if (cmd.clr_step) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cmd.eval) begin
				mag_q <= mag_q + MAG_W'(dm);
				en_q  <= en_q + ENERGY_W'(de);
			end
			done_q <= cmd.eval;
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= RAD_W'(thr2_q) * RAD_W'(thr4_q);
		if (cmd.item_load) begin
			op_q   <= opcode;
			row_q  <= row;
			col_q  <= col;
			sv_q   <= spin_value;
			frac_q <= random_fraction;
			acc_q  <= '0;
		end else if (cmd.acc_add) begin
			acc_q <= acc_q + NSUM_W'($signed(ram_rdata));
		end
		if (cmd.cap_center) begin
			center_q <= ram_rdata;
		end
		if (cmd.eval) begin
			site_spin_q <= new_spin;
			flipped_q   <= do_flip;
		end
	end

endmodule

// ===== design/ims_ctrl.sv =====
// ----------------------------------------------------------------------------
// ims_ctrl
// Sequencer: clearing pass, threshold roots, site reads and update.
// ----------------------------------------------------------------------------
module ims_ctrl import ims_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  ims_stat_t stat,
	output ims_cmd_t  cmd
);

	ctrl_state_t state_q;
	ctrl_state_t state_d;
	logic        pend_q;

	assign busy = (state_q != S_IDLE) || pend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_q  <= stat.cfg_wr || (pend_q && (state_q != S_IDLE));
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.rd_sel = SITE_C;
		cmd.sq_sel = SQ_ONE;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (stat.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (pend_q) begin
					cmd.sq_start = 1'b1;
					cmd.sq_sel   = SQ_ONE;
					state_d      = S_SQ1;
				end else if (start) begin
					cmd.item_load = 1'b1;
					state_d       = S_RC;
				end
			end
			S_SQ1: begin
				cmd.sq_sel = SQ_THREE;
				if (stat.sq_done) begin
					cmd.sq_store1 = 1'b1;
					cmd.sq_start  = 1'b1;
					state_d       = S_SQ3;
				end
			end
			S_SQ3: begin
				cmd.sq_sel = SQ_THREE;
				if (stat.sq_done) begin
					cmd.sq_store3 = 1'b1;
					state_d       = S_IDLE;
				end
			end
			S_RC: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = SITE_C;
				state_d    = S_RU;
			end
			S_RU: begin
				cmd.rd_en      = 1'b1;
				cmd.rd_sel     = SITE_U;
				cmd.cap_center = 1'b1;
				state_d        = S_RD;
			end
			S_RD: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_sel  = SITE_D;
				cmd.acc_add = 1'b1;
				state_d     = S_RL;
			end
			S_RL: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_sel  = SITE_L;
				cmd.acc_add = 1'b1;
				state_d     = S_RR;
			end
			S_RR: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_sel  = SITE_R;
				cmd.acc_add = 1'b1;
				state_d     = S_SUM;
			end
			S_SUM: begin
				cmd.acc_add = 1'b1;
				state_d     = S_EVAL;
			end
			S_EVAL: begin
				cmd.eval = 1'b1;
				state_d  = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ===== design/ising_metropolis_spin_update.sv =====
// done is registered from S_EVAL, after read states S_RC to S_RR and S_SUM; new items are
// taken only in S_IDLE, paced by the five site reads through the one spin RAM read port
// after reset, busy stays high for a clearing pass that zeroes every site
// a threshold write raises busy while the iterative root unit derives the odd-d thresholds;
// results cannot be stalled
// ----------------------------------------------------------------------------
// ising_metropolis_spin_update
// Metropolis spin update on a periodic square lattice with running totals.
// ----------------------------------------------------------------------------
module ising_metropolis_spin_update import ims_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic                       opcode,
	input  logic [COORD_W-1:0]         row,
	input  logic [COORD_W-1:0]         col,
	input  logic signed [SPIN_W-1:0]   spin_value,
	input  logic [FRAC_W-1:0]          random_fraction,
	output logic                       done,
	output logic signed [SPIN_W-1:0]   site_spin,
	output logic                       flipped,
	output logic signed [MAG_W-1:0]    magnetization,
	output logic signed [ENERGY_W-1:0] energy,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [FRAC_W-1:0]          cfg_data
);

	ims_cmd_t  cmd;
	ims_stat_t stat;

	assign cfg_ready = 1'b1;

	ims_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.cmd    (cmd)
	);

	ims_datapath u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.opcode          (opcode),
		.row             (row),
		.col             (col),
		.spin_value      (spin_value),
		.random_fraction (random_fraction),
		.done            (done),
		.site_spin       (site_spin),
		.flipped         (flipped),
		.magnetization   (magnetization),
		.energy          (energy)
	);

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Metropolis spin update block. A driver feeds
// site writes and flip attempts from a queue, mostly packed into a small
// window of the lattice so neighbours are occupied, with full-lattice noise.
// A monitor predicts every transfer against a local copy of the lattice,
// totals and thresholds, and checks each done strobe field by field.
// ----------------------------------------------------------------------------
module tb_top;
	import ims_pkg::*;

	localparam logic signed [SPIN_W-1:0] SV_EMPTY   = 2'b00;
	localparam logic signed [SPIN_W-1:0] SV_POS     = 2'b01;
	localparam logic signed [SPIN_W-1:0] SV_NEG_SAT = 2'b10;
	localparam logic signed [SPIN_W-1:0] SV_NEG     = 2'b11;
	localparam logic [FRAC_W-1:0]        FRAC_MAX   = '1;

	typedef struct packed {
		logic                     op;
		logic [COORD_W-1:0]       row;
		logic [COORD_W-1:0]       col;
		logic signed [SPIN_W-1:0] spin;
		logic [FRAC_W-1:0]        frac;
	} spin_item_t;

	typedef struct packed {
		logic signed [SPIN_W-1:0]   spin;
		logic                       flipped;
		logic signed [MAG_W-1:0]    mag;
		logic signed [ENERGY_W-1:0] energy;
	} spin_result_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       start = 1'b0;
	logic                       busy;
	logic                       opcode = OP_WRITE;
	logic [COORD_W-1:0]         row = '0;
	logic [COORD_W-1:0]         col = '0;
	logic signed [SPIN_W-1:0]   spin_value = SV_EMPTY;
	logic [FRAC_W-1:0]          random_fraction = '0;
	logic                       done;
	logic signed [SPIN_W-1:0]   site_spin;
	logic                       flipped;
	logic signed [MAG_W-1:0]    magnetization;
	logic signed [ENERGY_W-1:0] energy;
	logic                       cfg_valid = 1'b0;
	logic                       cfg_ready;
	logic [CFG_IDX_W-1:0]       cfg_index = REG_THR_TWO;
	logic [FRAC_W-1:0]          cfg_data = '0;

	ising_metropolis_spin_update u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.opcode         (opcode),
		.row            (row),
		.col            (col),
		.spin_value     (spin_value),
		.random_fraction(random_fraction),
		.done           (done),
		.site_spin      (site_spin),
		.flipped        (flipped),
		.magnetization  (magnetization),
		.energy         (energy),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	always #1 clk = ~clk;

	spin_item_t   site_ops[$];
	spin_result_t predicted_updates[$];
	int           mismatch_count = 0;
	bit           gaps_on = 1'b1;
	int           idle_left = 0;
	spin_item_t   next_op;
	spin_item_t   seen_op;
	spin_result_t want;

	// local copy of lattice, totals and thresholds
	logic signed [SPIN_W-1:0] lattice [SITE_COUNT];
	int                       mag_sum = 0;
	int                       energy_sum = 0;
	logic [FRAC_W-1:0]        thr_one = '0;
	logic [FRAC_W-1:0]        thr_two = '0;
	logic [FRAC_W-1:0]        thr_three = '0;
	logic [FRAC_W-1:0]        thr_four = '0;

	initial begin
		foreach (lattice[i]) lattice[i] = SV_EMPTY;
	end

	function automatic logic [ROOT_W-1:0] floor_root(logic [RAD_W-1:0] v);
		logic [ROOT_W-1:0] r;
		logic [ROOT_W-1:0] t;
		r = '0;
		for (int b = ROOT_W - 1; b >= 0; b--) begin
			t = r | (ROOT_W'(1) << b);
			if (RAD_W'(t) * RAD_W'(t) <= v) r = t;
		end
		return r;
	endfunction

	function automatic spin_result_t metropolis_step(spin_item_t it);
		logic [COORD_W-1:0] up;
		logic [COORD_W-1:0] dn;
		logic [COORD_W-1:0] lf;
		logic [COORD_W-1:0] rt;
		logic [ADDR_W-1:0]  idx;
		logic [FRAC_W-1:0]  thr;
		spin_result_t       res;
		int                 s;
		int                 n;
		int                 ns;
		int                 d;
		up  = it.row - 1'b1;
		dn  = it.row + 1'b1;
		lf  = it.col - 1'b1;
		rt  = it.col + 1'b1;
		idx = {it.row, it.col};
		s   = lattice[idx];
		n   = 0;
		n  += lattice[{up, it.col}];
		n  += lattice[{dn, it.col}];
		n  += lattice[{it.row, lf}];
		n  += lattice[{it.row, rt}];
		res.flipped = 1'b0;
		if (it.op == OP_WRITE) begin
			ns = (it.spin == SV_EMPTY) ? 0 : (it.spin == SV_POS) ? 1 : -1;
			mag_sum    += ns - s;
			energy_sum -= (ns - s) * n;
			lattice[idx] = SPIN_W'(ns);
			s = ns;
		end else if (s != 0) begin
			d = s * n;
			case (d)
				1:       thr = thr_one;
				2:       thr = thr_two;
				3:       thr = thr_three;
				default: thr = thr_four;
			endcase
			if (d <= 0 || it.frac < thr) begin
				s = -s;
				lattice[idx] = SPIN_W'(s);
				mag_sum    += 2 * s;
				energy_sum += 2 * d;
				res.flipped = 1'b1;
			end
		end
		res.spin   = SPIN_W'(s);
		res.mag    = MAG_W'(mag_sum);
		res.energy = ENERGY_W'(energy_sum);
		return res;
	endfunction

	task automatic report_mismatch(string field, int got, int exp_val);
		$display("mismatch %s: got %0d expected %0d at %0t", field, got, exp_val, $realtime);
		mismatch_count++;
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start     <= 1'b0;
			idle_left <= 0;
		end else if (!start || !busy) begin
			if (idle_left != 0) begin
				start     <= 1'b0;
				idle_left <= idle_left - 1;
			end else if (site_ops.size() != 0) begin
				next_op = site_ops.pop_front();
				start           <= 1'b1;
				opcode          <= next_op.op;
				row             <= next_op.row;
				col             <= next_op.col;
				spin_value      <= next_op.spin;
				random_fraction <= next_op.frac;
				if (gaps_on && $urandom_range(0, 3) == 0) idle_left <= $urandom_range(1, 15);
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor and predictor
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				if (predicted_updates.size() == 0) begin
					report_mismatch("unexpected result", 1, 0);
				end else begin
					want = predicted_updates.pop_front();
					if (site_spin !== want.spin)
						report_mismatch("site_spin", site_spin, $signed(want.spin));
					if (flipped !== want.flipped)
						report_mismatch("flipped", flipped, want.flipped);
					if (magnetization !== want.mag)
						report_mismatch("magnetization", magnetization, $signed(want.mag));
					if (energy !== want.energy)
						report_mismatch("energy", energy, $signed(want.energy));
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_THR_TWO:  thr_two = cfg_data;
					REG_THR_FOUR: thr_four = cfg_data;
					default: ;
				endcase
				thr_one   = floor_root({thr_two, 32'h0});
				thr_three = floor_root(RAD_W'(thr_two) * RAD_W'(thr_four));
			end
			if (start && !busy) begin
				seen_op.op   = opcode;
				seen_op.row  = row;
				seen_op.col  = col;
				seen_op.spin = spin_value;
				seen_op.frac = random_fraction;
				predicted_updates.push_back(metropolis_step(seen_op));
			end
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [FRAC_W-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_thresholds(logic [FRAC_W-1:0] two, logic [FRAC_W-1:0] four);
		write_reg(REG_THR_TWO, two);
		write_reg(REG_THR_FOUR, four);
		@(negedge clk);
	endtask

	task automatic wait_idle();
		@(negedge clk);
		while (site_ops.size() != 0 || start || predicted_updates.size() != 0)
			@(negedge clk);
	endtask

	task automatic add_op(logic op, logic [COORD_W-1:0] r, logic [COORD_W-1:0] c,
			logic signed [SPIN_W-1:0] sv, logic [FRAC_W-1:0] frac);
		spin_item_t it;
		it.op   = op;
		it.row  = r;
		it.col  = c;
		it.spin = sv;
		it.frac = frac;
		site_ops.push_back(it);
	endtask

	// dense window around a random origin plus full-lattice noise
	task automatic add_random_ops(int count);
		spin_item_t         it;
		logic [COORD_W-1:0] r0;
		logic [COORD_W-1:0] c0;
		logic [FRAC_W-1:0]  base;
		int                 span;
		r0   = $urandom_range(0, 1) ? COORD_W'(LATTICE_SIDE - 2) : COORD_W'($urandom);
		c0   = $urandom_range(0, 1) ? COORD_W'(LATTICE_SIDE - 2) : COORD_W'($urandom);
		span = $urandom_range(3, 5);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 9) < 2) begin
				it.row = COORD_W'($urandom);
				it.col = COORD_W'($urandom);
			end else begin
				it.row = r0 + COORD_W'($urandom_range(0, span - 1));
				it.col = c0 + COORD_W'($urandom_range(0, span - 1));
			end
			it.op   = ($urandom_range(0, 9) < 4) ? OP_WRITE : OP_ATTEMPT;
			it.spin = ($urandom_range(0, 9) == 0) ? SV_EMPTY : SPIN_W'($urandom_range(1, 3));
			case ($urandom_range(0, 3))
				0, 1: it.frac = $urandom;
				2:    it.frac = FRAC_W'($urandom_range(0, 255));
				default: begin
					case ($urandom_range(0, 3))
						0:       base = thr_one;
						1:       base = thr_two;
						2:       base = thr_three;
						default: base = thr_four;
					endcase
					it.frac = base + FRAC_W'($urandom_range(0, 2)) - 1'b1;
				end
			endcase
			site_ops.push_back(it);
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		set_thresholds(32'h8000_0000, 32'h4000_0000);
		add_op(OP_WRITE,   6'd0,  6'd0,  SV_POS,     FRAC_MAX);
		add_op(OP_ATTEMPT, 6'd5,  6'd5,  SV_NEG,     '0);
		add_op(OP_WRITE,   6'd63, 6'd0,  SV_POS,     $urandom);
		add_op(OP_WRITE,   6'd0,  6'd63, SV_POS,     $urandom);
		add_op(OP_WRITE,   6'd1,  6'd0,  SV_NEG,     $urandom);
		add_op(OP_WRITE,   6'd0,  6'd1,  SV_POS,     $urandom);
		add_op(OP_ATTEMPT, 6'd0,  6'd0,  SV_EMPTY,   FRAC_MAX);
		add_op(OP_ATTEMPT, 6'd0,  6'd0,  SV_NEG_SAT, '0);
		add_op(OP_ATTEMPT, 6'd0,  6'd0,  SV_POS,     FRAC_MAX);
		add_op(OP_WRITE,   6'd1,  6'd0,  SV_NEG_SAT, $urandom);
		add_op(OP_WRITE,   6'd1,  6'd0,  SV_EMPTY,   $urandom);
		add_op(OP_ATTEMPT, 6'd0,  6'd0,  SV_NEG,     '0);
		add_op(OP_ATTEMPT, 6'd0,  6'd0,  SV_NEG,     FRAC_MAX);
		add_op(OP_WRITE,   6'd1,  6'd0,  SV_POS,     $urandom);
		add_op(OP_ATTEMPT, 6'd0,  6'd0,  SV_POS,     FRAC_MAX);
		add_op(OP_ATTEMPT, 6'd0,  6'd0,  SV_POS,     '0);
		add_op(OP_WRITE,   6'd63, 6'd63, SV_POS,     '0);
		add_op(OP_ATTEMPT, 6'd63, 6'd63, SV_EMPTY,   FRAC_MAX);
		add_op(OP_WRITE,   6'd0,  6'd63, SV_EMPTY,   $urandom);
		add_op(OP_WRITE,   6'd1,  6'd0,  SV_NEG,     $urandom);
		add_op(OP_WRITE,   6'd0,  6'd0,  SV_POS,     $urandom);
		add_op(OP_ATTEMPT, 6'd0,  6'd0,  SV_POS,     FRAC_MAX);
		add_op(OP_ATTEMPT, 6'd0,  6'd0,  SV_POS,     '0);
		add_op(OP_WRITE,   6'd0,  6'd1,  SV_EMPTY,   $urandom);
		add_op(OP_ATTEMPT, 6'd0,  6'd0,  SV_NEG,     FRAC_MAX);
		wait_idle();

		set_thresholds('0, '0);
		add_random_ops(230);
		wait_idle();

		set_thresholds(FRAC_MAX, FRAC_MAX);
		add_random_ops(230);
		wait_idle();

		set_thresholds($urandom, $urandom);
		add_random_ops(230);
		wait_idle();

		set_thresholds(FRAC_MAX, '0);
		add_random_ops(230);
		wait_idle();

		set_thresholds('0, FRAC_MAX);
		add_random_ops(230);
		wait_idle();

		// no idling in the last stretch
		gaps_on = 1'b0;
		set_thresholds($urandom, $urandom);
		add_random_ops(230);
		wait_idle();

		repeat (20) @(posedge clk);
		if (mismatch_count == 0 && predicted_updates.size() == 0) begin
			$display("PASS ising_metropolis_spin_update");
		end else begin
			$display("FAIL ising_metropolis_spin_update");
		end
		$finish;
	end

	initial begin
		#1000000;
		$display("FAIL ising_metropolis_spin_update");
		$finish;
	end

endmodule
